@@ hdl/sensor_frame_pec_checker_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame PEC checker
// Concurrent checks, clocked by clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_PEC_CHECKER_MACROS_SVH
`define SENSOR_FRAME_PEC_CHECKER_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define SFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SFPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SFPC_ASSERT(lbl, prop, msg)
`define SFPC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hdl/sfpc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpc_pkg
// Shared constants, types and the CRC-8 step of the sensor frame PEC checker.
// ----------------------------------------------------------------------------
package sfpc_pkg;

  localparam int PIXEL_COUNT = 16;
  localparam int WORD_COUNT  = PIXEL_COUNT + 1;
  localparam int DATA_BYTES  = 2 * WORD_COUNT;
  localparam int IDLE_POS    = DATA_BYTES + 1;
  localparam int POS_W       = $clog2(IDLE_POS + 1);
  localparam int ADDR_W      = $clog2(WORD_COUNT);
  localparam int IDX_W       = 5;
  localparam int WORD_W      = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [6:0] DEV_ADDR_RESET = 7'd10;
  localparam logic [7:0] READ_CMD_RESET = 8'd76;

  // Register index, taken from paddr[2].
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_READ_COMMAND   = 1'b1;

  typedef enum logic [2:0] {
    ST_SEED_WR,
    ST_SEED_CMD,
    ST_SEED_RD,
    ST_RUN,
    ST_DRAIN
  } sfpc_state_e;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] read_cmd;
    logic       reseed;
  } sfpc_cfg_t;

  // One byte through the MSB-first CRC-8, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] x;
    x = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

endpackage

@@ hdl/sensor_frame_pec_checker.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_pec_checker
// Byte-wise sensor frame receiver with SMBus-style CRC-8 PEC check.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+---------------------------------
//  input    | start / busy                  | rx_byte_i, frame_start_i
//  result   | result_valid_o (one cycle)    | word_value_o, word_index_o,
//           |                               | frame_status_o, last_result_o
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  A transfer on the input side completes at a rising edge with start high and
//  busy low. Data bytes and failed PEC bytes leave busy low, so the next byte
//  need not wait. After a matching PEC byte the block is busy while the word
//  memory drains at one read per cycle, then while the seed is recomputed in
//  ST_SEED_WR, ST_SEED_CMD and ST_SEED_RD, and only then takes the next byte.
//  After reset the seed is computed in those states, one CRC step per seed
//  byte, with busy high; a register write holds busy high for the cycle after
//  the write and then through the seed states. No clearing pass is needed.
//  A result is shown for exactly one cycle; the receiver cannot stall it.
//
//  The frame holds 1+PIXEL_COUNT little-endian words followed by the PEC
//  byte. The CRC is seeded with the bus write byte, the read command and the
//  bus read byte, then runs over the data bytes; the PEC byte is compared
//  against it. The assembled words live in a single-port-read synchronous
//  memory. Writes happen only while bytes arrive and reads only while
//  draining, so the two never touch the same entry in the same cycle.
//
// ----------------------------------------------------------------------------
`include "sensor_frame_pec_checker_macros.svh"

module sensor_frame_pec_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Byte input
  input  logic                         start,
  output logic                         busy,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         frame_start_i,
  // Results
  output logic                         result_valid_o,
  output logic [sfpc_pkg::WORD_W-1:0]  word_value_o,
  output logic [sfpc_pkg::IDX_W-1:0]   word_index_o,
  output logic                         frame_status_o,
  output logic                         last_result_o,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfpc_pkg::PADDR_W-1:0] paddr,
  input  logic [sfpc_pkg::PDATA_W-1:0] pwdata,
  output logic [sfpc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import sfpc_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

  sfpc_cfg_t cfg;

  sfpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfpc_state_e state_q, state_d;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        seed_q, seed_d;
  logic [7:0]        pend_q, pend_d;
  logic [ADDR_W-1:0] drain_idx_q, drain_idx_d;

  logic              res_valid_q, res_valid_d;
  logic              res_err_q, res_err_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              res_last_q, res_last_d;
  logic [WORD_W-1:0] rd_data_q;

  logic              accept;
  logic [POS_W-1:0]  pos_eff;
  logic [7:0]        crc_eff;
  logic [7:0]        crc_next;
  logic              in_data;
  logic              at_pec;
  logic              pec_ok;
  logic              mem_we;
  logic              mem_re;

  // Bytes are taken only in the run state, and not in the cycle after a
  // register write, since the seed is about to be recomputed.
  assign busy     = (state_q != ST_RUN) | cfg.reseed;

  // A frame start restarts the count and the CRC before the byte is taken.
  assign accept   = start & ~busy;
  assign pos_eff  = frame_start_i ? '0 : pos_q;
  assign crc_eff  = frame_start_i ? seed_q : crc_q;
  assign crc_next = crc8_byte(crc_eff, rx_byte_i);
  assign in_data  = pos_eff < POS_W'(DATA_BYTES);
  assign at_pec   = pos_eff == POS_W'(DATA_BYTES);
  assign pec_ok   = crc_eff == rx_byte_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SEED_WR:  state_d = ST_SEED_CMD;
      ST_SEED_CMD: state_d = ST_SEED_RD;
      ST_SEED_RD:  state_d = ST_RUN;
      ST_RUN: begin
        if (accept && at_pec && pec_ok) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_idx_q == LAST_ADDR) begin
          state_d = ST_SEED_WR;
        end
      end
      default: state_d = ST_SEED_WR;
    endcase
    // New register values always go through a fresh seed computation.
    if (cfg.reseed && (state_q != ST_DRAIN)) begin
      state_d = ST_SEED_WR;
    end
  end

  // Outputs and datapath.
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    seed_d      = seed_q;
    pend_d      = pend_q;
    drain_idx_d = drain_idx_q;
    res_valid_d = 1'b0;
    res_err_d   = 1'b0;
    res_idx_d   = '0;
    res_last_d  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unique case (state_q)
      ST_SEED_WR: begin
        seed_d = crc8_byte(8'h00, {cfg.dev_addr, 1'b0});
      end
      ST_SEED_CMD: begin
        seed_d = crc8_byte(seed_q, cfg.read_cmd);
      end
      ST_SEED_RD: begin
        seed_d = crc8_byte(seed_q, {cfg.dev_addr, 1'b1});
        // Only a frame that has not yet begun picks up the new seed.
        if (pos_q == '0) begin
          crc_d = seed_d;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (in_data) begin
            crc_d = crc_next;
            pos_d = POS_W'(pos_eff + 1'b1);
            if (!pos_eff[0]) begin
              pend_d = rx_byte_i;
            end else begin
              mem_we = 1'b1;
            end
          end else if (at_pec) begin
            pos_d = POS_W'(IDLE_POS);
            crc_d = crc_eff;
            if (!pec_ok) begin
              res_valid_d = 1'b1;
              res_err_d   = 1'b1;
              res_last_d  = 1'b1;
            end else begin
              drain_idx_d = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        mem_re      = 1'b1;
        res_valid_d = 1'b1;
        res_idx_d   = IDX_W'(drain_idx_q);
        res_last_d  = drain_idx_q == LAST_ADDR;
        drain_idx_d = ADDR_W'(drain_idx_q + 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED_WR;
      pos_q       <= '0;
      crc_q       <= '0;
      seed_q      <= '0;
      pend_q      <= '0;
      drain_idx_q <= '0;
      res_valid_q <= 1'b0;
      res_err_q   <= 1'b0;
      res_idx_q   <= '0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      seed_q      <= seed_d;
      pend_q      <= pend_d;
      drain_idx_q <= drain_idx_d;
      res_valid_q <= res_valid_d;
      res_err_q   <= res_err_d;
      res_idx_q   <= res_idx_d;
      res_last_q  <= res_last_d;
    end
  end

  // Word memory: written on the high byte of each word, read while draining.
  logic [WORD_W-1:0] word_mem [WORD_COUNT];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      word_mem[pos_eff[ADDR_W:1]] <= {rx_byte_i, pend_q};
    end
    if (mem_re) begin
      rd_data_q <= word_mem[drain_idx_q];
    end
  end

  assign result_valid_o = res_valid_q;
  assign word_value_o   = res_err_q ? '0 : rd_data_q;
  assign word_index_o   = res_idx_q;
  assign frame_status_o = res_err_q;
  assign last_result_o  = res_last_q;

  // A result comes only from a drain read or from a failed PEC compare.
  `SFPC_ASSERT(a_result_source, result_valid_o |-> $past(state_q == ST_DRAIN || accept), "stray result")
  // Nothing follows the final result of a frame.
  `SFPC_ASSERT(a_quiet_after_last, (result_valid_o && last_result_o) |=> !result_valid_o, "result after last")
  // A good frame drains without gaps.
  `SFPC_ASSERT(a_drain_dense, (result_valid_o && !frame_status_o && !last_result_o) |=> result_valid_o, "drain gap")
  // The memory is never written and read in the same cycle.
  `SFPC_ASSERT_NEVER(a_mem_overlap, mem_we && mem_re, "word memory written while draining")
  // The byte count never passes the idle position.
  `SFPC_ASSERT(a_pos_range, pos_q <= POS_W'(IDLE_POS), "byte position out of range")

endmodule

@@ hdl/sfpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfpc_cfg_regs
// APB register file holding the bus address and the read command.
// ----------------------------------------------------------------------------
module sfpc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfpc_pkg::PADDR_W-1:0] paddr,
  input  logic [sfpc_pkg::PDATA_W-1:0] pwdata,
  output logic [sfpc_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,
  output sfpc_pkg::sfpc_cfg_t        cfg_o
);
  import sfpc_pkg::*;

  logic [6:0] dev_addr_q, dev_addr_d;
  logic [7:0] read_cmd_q, read_cmd_d;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    dev_addr_d = dev_addr_q;
    read_cmd_d = read_cmd_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEVICE_ADDRESS: dev_addr_d = pwdata[6:0];
        REG_READ_COMMAND:   read_cmd_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICE_ADDRESS: prdata = PDATA_W'(dev_addr_q);
      REG_READ_COMMAND:   prdata = PDATA_W'(read_cmd_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RESET;
      read_cmd_q <= READ_CMD_RESET;
    end else begin
      dev_addr_q <= dev_addr_d;
      read_cmd_q <= read_cmd_d;
    end
  end

  // The reseed request lines up with the registers taking their new values.
  logic reseed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reseed_q <= 1'b0;
    end else begin
      reseed_q <= wr_en;
    end
  end

  assign cfg_o.dev_addr = dev_addr_q;
  assign cfg_o.read_cmd = read_cmd_q;
  assign cfg_o.reseed   = reseed_q;

endmodule

@@ bench/sensor_frame_pec_checker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_frame_pec_checker_test
// Self-checking bench for the sensor frame PEC checker. Frames are sent one
// byte at a time through the start/busy port, and registers are set over APB.
// A built-in predictor of the CRC and the word store, or a hand-made entry,
// gives each result, and every result strobe is compared field by field.
// ----------------------------------------------------------------------------
module sensor_frame_pec_checker_test;

  import sfpc_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 100;
  // Drain of the word store plus the reseed, with some margin.
  localparam int SETTLE_CYCLES  = 2 * WORD_COUNT + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PLAN_ROWS      = 8;
  localparam logic [POS_W-1:0] FULL_FRAME = POS_W'(DATA_BYTES);

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_WALK, FILL_RANDOM} fill_kind_e;
  typedef enum logic [1:0] {PEC_GOOD, PEC_BAD, PEC_NONE} pec_kind_e;
  typedef enum logic [1:0] {CHECK_MODEL, CHECK_ERROR, CHECK_FILL} check_kind_e;

  // One frame (or a piece of one) of stimulus. Data bytes first_byte up to,
  // but not including, end_byte are sent, then the PEC byte if asked for,
  // then tail bytes that the block should ignore.
  typedef struct packed {
    logic             set_cfg;
    logic [6:0]       dev;
    logic [7:0]       cmd;
    logic             with_start;
    logic [POS_W-1:0] first_byte;
    logic [POS_W-1:0] end_byte;
    fill_kind_e       fill;
    pec_kind_e        pec;
    logic [2:0]       tail;
    check_kind_e      check;
  } plan_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              status;
    logic              last;
  } frame_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic [7:0]         rx_byte_i     = 8'h00;
  logic               frame_start_i = 1'b0;
  logic               result_valid_o;
  logic [WORD_W-1:0]  word_value_o;
  logic [IDX_W-1:0]   word_index_o;
  logic               frame_status_o;
  logic               last_result_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [PDATA_W-1:0] pwdata        = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predictor state: registers, frame position, running CRC and word store.
  logic [6:0]        cfg_dev       = DEV_ADDR_RESET;
  logic [7:0]        cfg_cmd       = READ_CMD_RESET;
  logic [POS_W-1:0]  frame_pos     = '0;
  logic [7:0]        frame_crc;
  logic [7:0]        low_byte      = 8'h00;
  logic [WORD_W-1:0] stored_words [WORD_COUNT];

  frame_result_t pending_results [$];
  plan_row_t     frame_plan [PLAN_ROWS];
  int            error_count = 0;
  int            frame_bytes = 0;
  int            idle_cycles = 0;
  bit            idle_on     = 1'b1;

  sensor_frame_pec_checker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .result_valid_o (result_valid_o),
    .word_value_o   (word_value_o),
    .word_index_o   (word_index_o),
    .frame_status_o (frame_status_o),
    .last_result_o  (last_result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bit-serial CRC-8, polynomial x^8+x^2+x+1, MSB first, no final xor.
  function automatic logic [7:0] crc_shift(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // The PEC covers the bus write byte, the command and the bus read byte first.
  function automatic logic [7:0] pec_seed();
    logic [7:0] c;
    c = crc_shift(8'h00, {cfg_dev, 1'b0});
    c = crc_shift(c, cfg_cmd);
    return crc_shift(c, {cfg_dev, 1'b1});
  endfunction

  // Takes one accepted byte into the predictor. With keep set, the results
  // that the byte causes join the queue; otherwise the caller has already
  // queued results typed in by hand.
  function automatic void absorb_byte(input logic [7:0] value, input logic opens_frame,
                                      input bit keep);
    frame_result_t r;
    if (opens_frame) begin
      frame_pos = '0;
      frame_crc = pec_seed();
    end
    if (frame_pos < FULL_FRAME) begin
      frame_bytes++;
      frame_crc = crc_shift(frame_crc, value);
      if (!frame_pos[0]) begin
        low_byte = value;
      end else begin
        stored_words[frame_pos[POS_W-1:1]] = {value, low_byte};
      end
      frame_pos++;
    end else if (frame_pos == FULL_FRAME) begin
      frame_bytes++;
      frame_pos = POS_W'(IDLE_POS);
      if (keep && frame_crc != value) begin
        r = '{value: '0, index: '0, status: 1'b1, last: 1'b1};
        pending_results.push_back(r);
      end else if (keep) begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          r = '{value: stored_words[k], index: IDX_W'(k), status: 1'b0,
                last: (k == WORD_COUNT - 1)};
          pending_results.push_back(r);
        end
      end
    end
    // Bytes after the PEC without a frame start fall through untouched.
  endfunction

  // A register write reseeds the CRC only before the first byte of a frame.
  function automatic void apply_register(input logic reg_idx, input logic [7:0] value);
    if (reg_idx == REG_DEVICE_ADDRESS) begin
      cfg_dev = value[6:0];
    end else begin
      cfg_cmd = value;
    end
    if (frame_pos == '0) begin
      frame_crc = pec_seed();
    end
  endfunction

  function automatic logic [7:0] register_value(input logic reg_idx);
    return (reg_idx == REG_DEVICE_ADDRESS) ? {1'b0, cfg_dev} : cfg_cmd;
  endfunction

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: the receiver cannot stall, so every strobe is a transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    frame_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual value %h index %0d status %b",
                 $time, word_value_o, word_index_o, frame_status_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("word_value", want.value, word_value_o);
        check_field("word_index", want.index, word_index_o);
        check_field("frame_status", want.status, frame_status_o);
        check_field("last_result", want.last, last_result_o);
      end
    end
  end

  // The watchdog restarts on any transfer: a byte, a result or a register access.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("sensor_frame_pec_checker_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one byte and holds it until busy is low at a rising edge. A short
  // random hold-off may follow, which lands on every phase of the block's
  // work, the drain of the word store included.
  task automatic send_byte(input logic [7:0] value, input logic opens_frame, input bit keep);
    start         <= 1'b1;
    rx_byte_i     <= value;
    frame_start_i <= opens_frame;
    do @(posedge clk_i); while (busy);
    absorb_byte(value, opens_frame, keep);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // APB read; prdata is sampled at the edge that completes the access phase.
  task automatic read_register(input logic reg_idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register readback", register_value(reg_idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_register(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register(reg_idx, value);
    read_register(reg_idx);
  endtask

  // Registers change only with the block idle: every result in, and then the
  // drain and reseed given time to finish, since a partial frame leaves
  // nothing in the queue to wait on.
  task automatic program_config(input logic [6:0] dev, input logic [7:0] cmd);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(REG_DEVICE_ADDRESS, {1'b0, dev});
    write_register(REG_READ_COMMAND, cmd);
  endtask

  function automatic logic [7:0] fill_byte(input fill_kind_e fill, input int pos);
    logic [7:0] walk;
    walk = 8'h01 << ((pos >> 1) % 8);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_WALK: return pos[0] ? ~walk : walk;
      default:   return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one row. The good PEC is read off the predictor's running CRC once
  // the data bytes are in; a bad one differs from it in at least one bit.
  task automatic send_frame(input plan_row_t row);
    logic [7:0]    pec;
    frame_result_t r;
    if (row.set_cfg) begin
      program_config(row.dev, row.cmd);
    end
    for (int i = row.first_byte; i < row.end_byte; i++) begin
      send_byte(fill_byte(row.fill, i), row.with_start && i == row.first_byte, 1'b1);
    end
    if (row.pec != PEC_NONE) begin
      pec = frame_crc;
      if (row.pec == PEC_BAD) begin
        pec ^= 8'($urandom_range(1, 255));
      end
      // Results that can be read off at a glance are queued by hand, ahead of
      // the PEC byte, since they may arrive during the hold-off after it.
      if (row.check == CHECK_ERROR) begin
        r = '{value: '0, index: '0, status: 1'b1, last: 1'b1};
        pending_results.push_back(r);
      end else if (row.check == CHECK_FILL) begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          r = '{value: (row.fill == FILL_ONES) ? 16'hFFFF : 16'h0000,
                index: IDX_W'(k), status: 1'b0, last: (k == WORD_COUNT - 1)};
          pending_results.push_back(r);
        end
      end
      send_byte(pec, 1'b0, row.check == CHECK_MODEL);
      repeat (row.tail) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t row;
    int        target;
    int        roll;

    frame_crc = pec_seed();

    // Directed rows, in order:
    //  - the first frame after reset, with no frame start and the reset
    //    registers, all zeros, then bytes after the PEC that must be ignored;
    //  - all ones with a good PEC, and again with a bad one;
    //  - a frame abandoned part way and restarted by a frame start;
    //  - both register extremes, including a write in the middle of a frame
    //    that must leave the rest of that frame on the old seed.
    frame_plan = '{
      '{1'b0, 7'd0,   8'd0,   1'b0, '0,        FULL_FRAME, FILL_ZERO,   PEC_GOOD, 3'd3,
        CHECK_FILL},
      '{1'b0, 7'd0,   8'd0,   1'b1, '0,        FULL_FRAME, FILL_ONES,   PEC_GOOD, 3'd0,
        CHECK_FILL},
      '{1'b0, 7'd0,   8'd0,   1'b1, '0,        FULL_FRAME, FILL_ONES,   PEC_BAD,  3'd0,
        CHECK_ERROR},
      '{1'b0, 7'd0,   8'd0,   1'b1, '0,        6'd11,      FILL_WALK,   PEC_NONE, 3'd0,
        CHECK_MODEL},
      '{1'b0, 7'd0,   8'd0,   1'b1, '0,        FULL_FRAME, FILL_WALK,   PEC_GOOD, 3'd0,
        CHECK_MODEL},
      '{1'b1, 7'd0,   8'd0,   1'b1, '0,        FULL_FRAME, FILL_RANDOM, PEC_GOOD, 3'd0,
        CHECK_MODEL},
      '{1'b0, 7'd0,   8'd0,   1'b1, '0,        6'd20,      FILL_RANDOM, PEC_NONE, 3'd0,
        CHECK_MODEL},
      '{1'b1, 7'd127, 8'd255, 1'b0, 6'd20,     FULL_FRAME, FILL_RANDOM, PEC_GOOD, 3'd2,
        CHECK_MODEL}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block seeds its CRC after reset with busy high; the registers must
    // read back their reset values.
    while (busy) @(posedge clk_i);
    read_register(REG_DEVICE_ADDRESS);
    read_register(REG_READ_COMMAND);

    foreach (frame_plan[i]) send_frame(frame_plan[i]);

    // Random part. Most frames are whole and well formed with random content,
    // so that the drain is exercised often; the rest carry a bad PEC, stop
    // short, or pick up an abandoned frame without a frame start after a
    // register change. The last stretch runs with no hold-offs at all.
    target = frame_bytes + RANDOM_ITEMS;
    while (frame_bytes < target) begin
      idle_on = (frame_bytes + 40 < target) && ($urandom_range(0, 3) != 0);
      roll    = $urandom_range(0, 99);

      row.set_cfg = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       row.dev = 7'd0;
        1:       row.dev = 7'd127;
        default: row.dev = 7'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 3))
        0:       row.cmd = 8'd0;
        1:       row.cmd = 8'd255;
        default: row.cmd = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       row.fill = FILL_ZERO;
        1:       row.fill = FILL_ONES;
        2:       row.fill = FILL_WALK;
        default: row.fill = FILL_RANDOM;
      endcase
      row.with_start = 1'b1;
      row.first_byte = '0;
      row.end_byte   = FULL_FRAME;
      row.pec        = (roll < 75) ? PEC_GOOD : PEC_BAD;
      row.tail       = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 4)) : 3'd0;
      row.check      = CHECK_MODEL;

      if (frame_pos != '0 && frame_pos <= FULL_FRAME && roll < 50) begin
        // Carry on with the frame left open, under new registers.
        row.set_cfg    = 1'b1;
        row.with_start = 1'b0;
        row.first_byte = frame_pos;
      end else if (roll >= 88) begin
        row.end_byte = POS_W'($urandom_range(1, DATA_BYTES));
        row.pec      = PEC_NONE;
      end
      send_frame(row);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("sensor_frame_pec_checker_test: clean");
    end else begin
      $display("sensor_frame_pec_checker_test: errors");
    end
    $finish;
  end

endmodule
